// ===== rtl/annexb_nal_unit_splitter_assert.svh =====
// assertion macros for the annex b nal unit splitter
`ifndef ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH
`ifndef SYNTH
`define ANB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ANB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ANB_ASSERT(lbl, prop, msg)
`define ANB_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/anb_pkg.sv =====
// shared types and constants of the annex b nal unit splitter
`default_nettype none
package anb_pkg;
	localparam int LengthBitsDef = 20;
	localparam int MaxResults    = 5;
	localparam int QueueDepth    = 8;
	localparam int QueueIdxBits  = $clog2(QueueDepth);
	localparam int ResCntBits    = $clog2(MaxResults + 1);

	localparam logic [7:0] FzMask   = 8'h80;
	localparam logic [7:0] IdcMask  = 8'h60;
	localparam logic [7:0] TypeMask = 8'h1f;
	localparam logic [7:0] ByteZero = 8'h00;
	localparam logic [7:0] ByteOne  = 8'h01;
	localparam logic [2:0] CodeSize3 = 3'd3;
	localparam logic [2:0] CodeSize4 = 3'd4;

	typedef struct packed {
		logic [7:0] pbyte;
		logic       first;
		logic       last;
		logic [2:0] code_size;
		logic [7:0] header;
		logic       sync_err;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/anb_parse.sv =====
// start code detection, delay line and unit state; one input byte per take
`default_nettype none
module anb_parse #(
	parameter int LENGTH_BITS = anb_pkg::LengthBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             data_s1,
	input  logic                   eos_s1,
	output anb_pkg::res_t          res [anb_pkg::MaxResults],
	output logic [LENGTH_BITS-1:0] len [anb_pkg::MaxResults],
	output logic [anb_pkg::ResCntBits-1:0] res_n
);
	import anb_pkg::*;

	localparam logic [LENGTH_BITS:0] LenMax = {1'b0, {LENGTH_BITS{1'b1}}};

	logic [7:0]             held_q [4];
	logic [2:0]             hcnt_q;
	logic                   in_unit_q;
	logic                   err_rep_q;
	logic [2:0]             osize_q;
	logic [7:0]             hdr_q;
	logic                   first_pend_q;
	logic [LENGTH_BITS-1:0] bcnt_q;

	logic [7:0]             w [5];
	logic [2:0]             cnt;
	logic [7:0]             p1, p2, p3;
	logic                   have2, have3;
	logic                   is_one, sc4, sc3, start;
	logic [2:0]             rest, ne;
	logic                   closes;
	logic                   open_h, hunt_err;
	logic [LENGTH_BITS-1:0] base;
	logic [LENGTH_BITS:0]   sum;
	logic [LENGTH_BITS-1:0] satsum;
	logic [7:0]             hdr_eff;

	// window of held bytes plus the new byte, oldest first
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			w[i] = ByteZero;
		end
		p1 = ByteZero;
		p2 = ByteZero;
		p3 = ByteZero;
		have2 = 1'b0;
		have3 = 1'b0;
		cnt = 3'd1;
		case (hcnt_q)
			3'd0: begin
				w[0] = data_s1;
				cnt = 3'd1;
			end
			3'd1: begin
				w[0] = held_q[0];
				w[1] = data_s1;
				cnt = 3'd2;
				p1 = held_q[0];
			end
			3'd2: begin
				w[0] = held_q[0];
				w[1] = held_q[1];
				w[2] = data_s1;
				cnt = 3'd3;
				p1 = held_q[1];
				p2 = held_q[0];
				have2 = 1'b1;
			end
			3'd3: begin
				w[0] = held_q[0];
				w[1] = held_q[1];
				w[2] = held_q[2];
				w[3] = data_s1;
				cnt = 3'd4;
				p1 = held_q[2];
				p2 = held_q[1];
				p3 = held_q[0];
				have2 = 1'b1;
				have3 = 1'b1;
			end
			default: begin
				w[0] = held_q[0];
				w[1] = held_q[1];
				w[2] = held_q[2];
				w[3] = held_q[3];
				w[4] = data_s1;
				cnt = 3'd5;
				p1 = held_q[3];
				p2 = held_q[2];
				p3 = held_q[1];
				have2 = 1'b1;
				have3 = 1'b1;
			end
		endcase
	end

	assign is_one = (data_s1 == ByteOne);
	assign sc4 = have3 && (p3 == ByteZero) && (p2 == ByteZero) && (p1 == ByteZero) && is_one;
	assign sc3 = !sc4 && have2 && (p2 == ByteZero) && (p1 == ByteZero) && is_one;
	assign start = sc4 || sc3;
	assign rest = cnt - (sc4 ? CodeSize4 : CodeSize3);

	always_comb begin
		if (start) begin
			ne = rest;
			closes = 1'b1;
		end else if (eos_s1) begin
			ne = cnt;
			closes = 1'b1;
		end else if (cnt == 3'd5) begin
			ne = 3'd1;
			closes = 1'b0;
		end else begin
			ne = 3'd0;
			closes = 1'b0;
		end
	end

	assign open_h = is_one && (hcnt_q >= 3'd2);
	assign hunt_err = !err_rep_q && !open_h && ((data_s1 != ByteZero) || eos_s1);

	assign base = first_pend_q ? '0 : bcnt_q;
	assign sum = {1'b0, base} + {{(LENGTH_BITS-2){1'b0}}, ne};
	assign satsum = (sum > LenMax) ? LenMax[LENGTH_BITS-1:0] : sum[LENGTH_BITS-1:0];
	assign hdr_eff = first_pend_q ? w[0] : hdr_q;

	always_comb begin
		for (int k = 0; k < MaxResults; k++) begin
			res[k] = '0;
			len[k] = '0;
			if (in_unit_q) begin
				res[k].pbyte = w[k];
				res[k].first = first_pend_q && (k == 0);
				res[k].last = closes && (ne == 3'(k + 1));
				res[k].code_size = osize_q;
				res[k].header = hdr_eff;
				len[k] = res[k].last ? satsum : '0;
			end else if (k == 0) begin
				res[k].sync_err = 1'b1;
			end
		end
		res_n = in_unit_q ? ne : {2'b00, hunt_err};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= ByteZero;
			end
			hcnt_q <= 3'd0;
			in_unit_q <= 1'b0;
			err_rep_q <= 1'b0;
			osize_q <= CodeSize3;
			hdr_q <= ByteZero;
			first_pend_q <= 1'b1;
			bcnt_q <= '0;
		end else if (take) begin
			if (eos_s1) begin
				// stream ends: back to the reset state
				for (int i = 0; i < 4; i++) begin
					held_q[i] <= ByteZero;
				end
				hcnt_q <= 3'd0;
				in_unit_q <= 1'b0;
				err_rep_q <= 1'b0;
				osize_q <= CodeSize3;
				hdr_q <= ByteZero;
				first_pend_q <= 1'b1;
				bcnt_q <= '0;
			end else if (!in_unit_q) begin
				if (data_s1 == ByteZero) begin
					if (hcnt_q < 3'd3) begin
						hcnt_q <= hcnt_q + 3'd1;
					end
				end else if (open_h) begin
					in_unit_q <= 1'b1;
					hcnt_q <= 3'd0;
					osize_q <= (hcnt_q >= 3'd3) ? CodeSize4 : CodeSize3;
					first_pend_q <= 1'b1;
					bcnt_q <= '0;
				end else begin
					hcnt_q <= 3'd0;
					err_rep_q <= err_rep_q | hunt_err;
				end
			end else begin
				if (first_pend_q && (ne != 3'd0)) begin
					hdr_q <= w[0];
				end
				if (start) begin
					for (int i = 0; i < 4; i++) begin
						held_q[i] <= ByteZero;
					end
					hcnt_q <= 3'd0;
					osize_q <= sc4 ? CodeSize4 : CodeSize3;
					first_pend_q <= 1'b1;
					bcnt_q <= '0;
				end else begin
					if (cnt == 3'd5) begin
						for (int i = 0; i < 4; i++) begin
							held_q[i] <= w[i + 1];
						end
						hcnt_q <= 3'd4;
					end else begin
						for (int i = 0; i < 4; i++) begin
							held_q[i] <= w[i];
						end
						hcnt_q <= cnt;
					end
					first_pend_q <= first_pend_q && (ne == 3'd0);
					if (ne != 3'd0) begin
						bcnt_q <= satsum;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/anb_resq.sv =====
// result queue: takes up to five words per cycle, hands out one unless out_stall holds it
`default_nettype none
module anb_resq #(
	parameter int LENGTH_BITS = anb_pkg::LengthBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [anb_pkg::ResCntBits-1:0] push_n,
	input  anb_pkg::res_t          res [anb_pkg::MaxResults],
	input  logic [LENGTH_BITS-1:0] len [anb_pkg::MaxResults],
	output logic                   space_ok,
	output logic                   out_valid,
	input  logic                   out_stall,
	output anb_pkg::res_t          out_res,
	output logic [LENGTH_BITS-1:0] out_len
);
	import anb_pkg::*;

	localparam int CntBits = QueueIdxBits + 1;

	res_t                   ent_q [QueueDepth];
	logic [LENGTH_BITS-1:0] len_q [QueueDepth];
	logic [QueueIdxBits-1:0] wr_q, rd_q;
	logic [CntBits-1:0]     cnt_q;
	logic                   pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign space_ok = (cnt_q <= CntBits'(QueueDepth - MaxResults));
	assign out_res = ent_q[rd_q];
	assign out_len = len_q[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < QueueDepth; i++) begin
			if ({1'b0, QueueIdxBits'(i) - wr_q} < CntBits'(push_n)) begin
				ent_q[i] <= res[QueueIdxBits'(i) - wr_q];
				len_q[i] <= len[QueueIdxBits'(i) - wr_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QueueIdxBits'(push_n);
			if (pop) begin
				rd_q <= rd_q + QueueIdxBits'(1);
			end
			cnt_q <= cnt_q + CntBits'(push_n) - CntBits'(pop);
		end
	end

`include "annexb_nal_unit_splitter_assert.svh"
	`ANB_ASSERT(a_cnt_bound, cnt_q <= CntBits'(QueueDepth), "result queue overflow")
	`ANB_ASSERT_IMPL(a_push_room, push_n != '0, space_ok, "push without room")
	`ANB_ASSERT(a_ptr_track, (wr_q - rd_q) == cnt_q[QueueIdxBits-1:0], "queue pointers disagree")
endmodule
`default_nettype wire

// ===== rtl/annexb_nal_unit_splitter.sv =====
// top level of the annex b nal unit splitter
`default_nettype none
// Splits an H.264 Annex B byte stream into unit payload bytes, one stream
// byte per input word, start codes stripped. A byte is registered on accept
// and parsed into a result queue of eight words once the queue has room.
// Input is taken while the queue has room for five words: a steady stream
// runs at one byte per cycle while out_stall is low, and an end-of-stream
// flush (up to five words for one byte) holds the input until the queue
// drains to three words. Bytes before the first start code give at most one
// sync_error word and are dropped; end_of_stream returns the block to its
// reset state after its byte.
module annexb_nal_unit_splitter #(
	parameter int LENGTH_BITS = anb_pkg::LengthBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_stream,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             payload_byte,
	output logic                   first_of_unit,
	output logic                   last_of_unit,
	output logic [2:0]             start_code_size,
	output logic                   forbidden_zero,
	output logic [1:0]             reference_idc,
	output logic [4:0]             unit_type,
	output logic [LENGTH_BITS-1:0] unit_length,
	output logic                   sync_error
);
	import anb_pkg::*;

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   eos_s1;
	logic                   space_ok;
	logic                   take;
	res_t                   res [MaxResults];
	logic [LENGTH_BITS-1:0] len [MaxResults];
	logic [ResCntBits-1:0]  res_n;
	logic [ResCntBits-1:0]  push_n;
	res_t                   out_res;
	logic [7:0]             fz_m, idc_m, type_m;

	assign take = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;
	assign push_n = take ? res_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			eos_s1 <= end_of_stream;
		end
	end

	anb_parse #(.LENGTH_BITS(LENGTH_BITS)) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.data_s1 (data_s1),
		.eos_s1  (eos_s1),
		.res     (res),
		.len     (len),
		.res_n   (res_n)
	);

	anb_resq #(.LENGTH_BITS(LENGTH_BITS)) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res       (res),
		.len       (len),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.out_len   (unit_length)
	);

	// header fields of the unit's first byte
	assign fz_m = out_res.header & FzMask;
	assign idc_m = out_res.header & IdcMask;
	assign type_m = out_res.header & TypeMask;

	assign payload_byte = out_res.pbyte;
	assign first_of_unit = out_res.first;
	assign last_of_unit = out_res.last;
	assign start_code_size = out_res.code_size;
	assign forbidden_zero = fz_m[7];
	assign reference_idc = idc_m[6:5];
	assign unit_type = type_m[4:0];
	assign sync_error = out_res.sync_err;
endmodule
`default_nettype wire

// ===== tb/tb_annexb_nal_unit_splitter.sv =====
// self-checking testbench for the annex b nal unit splitter
`timescale 1ns / 1ps

module tb_annexb_nal_unit_splitter;
	import anb_pkg::*;

	localparam int LEN_W = LengthBitsDef;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 100;

	typedef struct packed {
		logic [7:0]       pbyte;
		logic             first;
		logic             last;
		logic [2:0]       code_sz;
		logic             fz;
		logic [1:0]       idc;
		logic [4:0]       utype;
		logic [LEN_W-1:0] ulen;
		logic             serr;
	} nal_word_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       data_byte = 8'h00;
	logic             end_of_stream = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       payload_byte;
	logic             first_of_unit;
	logic             last_of_unit;
	logic [2:0]       start_code_size;
	logic             forbidden_zero;
	logic [1:0]       reference_idc;
	logic [4:0]       unit_type;
	logic [LEN_W-1:0] unit_length;
	logic             sync_error;

	// parser state mirrored on the testbench side
	logic [7:0]       held [4];
	int unsigned      held_cnt;
	bit               in_unit;
	bit               err_seen;
	bit               first_due;
	logic [2:0]       code_sz;
	logic [7:0]       hdr;
	logic [LEN_W-1:0] run_len;

	nal_word_t        nal_words_due [$];
	nal_word_t        got_word;
	int unsigned      fails = 0;
	int unsigned      cycles = 0;
	int unsigned      stall_run = 0;
	bit               calm = 1'b0;

	annexb_nal_unit_splitter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_stream   (end_of_stream),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_byte    (payload_byte),
		.first_of_unit   (first_of_unit),
		.last_of_unit    (last_of_unit),
		.start_code_size (start_code_size),
		.forbidden_zero  (forbidden_zero),
		.reference_idc   (reference_idc),
		.unit_type       (unit_type),
		.unit_length     (unit_length),
		.sync_error      (sync_error)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void clear_parser();
		for (int i = 0; i < 4; i++) held[i] = ByteZero;
		held_cnt = 0;
		in_unit = 1'b0;
		err_seen = 1'b0;
		code_sz = CodeSize3;
		hdr = ByteZero;
		first_due = 1'b1;
		run_len = '0;
	endfunction

	function automatic void queue_sync_error();
		nal_word_t w;
		w = '0;
		w.serr = 1'b1;
		nal_words_due.push_back(w);
	endfunction

	function automatic void queue_payload(logic [7:0] b, bit last);
		nal_word_t w;
		bit first;
		first = first_due;
		if (first) begin
			hdr = b;
			first_due = 1'b0;
			run_len = '0;
		end
		if (run_len != '1)
			run_len++;
		w = '0;
		w.pbyte = b;
		w.first = first;
		w.last = last;
		w.code_sz = code_sz;
		w.fz = |(hdr & FzMask);
		w.idc = 2'((hdr & IdcMask) >> 5);
		w.utype = 5'(hdr & TypeMask);
		w.ulen = last ? run_len : '0;
		if (last) begin
			first_due = 1'b1;
			run_len = '0;
		end
		nal_words_due.push_back(w);
	endfunction

	function automatic void open_unit(logic [2:0] size);
		in_unit = 1'b1;
		held_cnt = 0;
		for (int i = 0; i < 4; i++) held[i] = ByteZero;
		code_sz = size;
		first_due = 1'b1;
		run_len = '0;
	endfunction

	// expected words for one accepted stream byte
	function automatic void parse_stream_byte(logic [7:0] b, bit eos);
		logic [7:0] win [5];
		int unsigned n;
		int unsigned cut;
		int unsigned rest;
		if (!in_unit) begin
			if (b == ByteZero) begin
				if (held_cnt < 3)
					held_cnt++;
			end else if (b == ByteOne && held_cnt >= 2) begin
				open_unit(held_cnt >= 3 ? CodeSize4 : CodeSize3);
				if (eos)
					clear_parser();
				return;
			end else begin
				held_cnt = 0;
				if (!err_seen) begin
					err_seen = 1'b1;
					queue_sync_error();
				end
			end
			if (eos) begin
				if (!err_seen)
					queue_sync_error();
				clear_parser();
			end
			return;
		end
		n = held_cnt > 4 ? 4 : held_cnt;
		for (int i = 0; i < 4; i++) win[i] = held[i];
		win[n] = b;
		n++;
		cut = 0;
		if (n >= 4 && win[n-4] == ByteZero && win[n-3] == ByteZero &&
				win[n-2] == ByteZero && win[n-1] == ByteOne)
			cut = 4;
		else if (n >= 3 && win[n-3] == ByteZero && win[n-2] == ByteZero &&
				win[n-1] == ByteOne)
			cut = 3;
		if (cut != 0) begin
			rest = n - cut;
			for (int i = 0; i < rest; i++) queue_payload(win[i], i + 1 == rest);
			open_unit(cut == 4 ? CodeSize4 : CodeSize3);
			if (eos)
				clear_parser();
			return;
		end
		if (eos) begin
			for (int i = 0; i < n; i++) queue_payload(win[i], i + 1 == n);
			clear_parser();
			return;
		end
		if (n == 5) begin
			queue_payload(win[0], 1'b0);
			for (int i = 0; i < 4; i++) held[i] = win[i+1];
			held_cnt = 4;
		end else begin
			for (int i = 0; i < n; i++) held[i] = win[i];
			held_cnt = n;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit eos);
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		parse_stream_byte(b, eos);
	endtask

	task automatic send_stream(input logic [7:0] s [$]);
		for (int i = 0; i < s.size(); i++) push_byte(s[i], i + 1 == s.size());
	endtask

	function automatic logic [7:0] rand_payload_byte();
		case ($urandom_range(0, 7))
			0, 1: return ByteZero;
			2: return ByteOne;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// leading zeros, both code sizes, code choice, empty unit, header extremes
	task automatic test_units_and_codes();
		logic [7:0] s [$];
		s = {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'he5, 8'hff, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h7f};
		send_stream(s);
	endtask

	// garbage before the first start code gives a single error word
	task automatic test_sync_loss();
		logic [7:0] s [$];
		s = {8'h47, 8'h00, 8'h02, 8'h00, 8'h00, 8'h01, 8'h1f, 8'h00};
		send_stream(s);
	endtask

	// end of stream while hunting, with and without a completed start code
	task automatic test_stream_end_hunting();
		logic [7:0] s [$];
		s = {8'h00, 8'h00};
		send_stream(s);
		s = {8'h00, 8'h00, 8'h01};
		send_stream(s);
		s = {8'h2a};
		send_stream(s);
	endtask

	task automatic test_random_streams();
		logic [7:0] s [$];
		int unsigned sent;
		int unsigned kind;
		int unsigned len;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			s = {};
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 8)) s.push_back(rand_payload_byte());
			end else begin
				if (kind == 1)
					s.push_back(8'($urandom_range(2, 255)));
				repeat ($urandom_range(0, 2)) s.push_back(ByteZero);
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						s.push_back(ByteZero);
					s.push_back(ByteZero);
					s.push_back(ByteZero);
					s.push_back(ByteOne);
					len = $urandom_range(0, 10);
					if (len > 0)
						s.push_back(8'($urandom_range(0, 255)));
					for (int i = 1; i < len; i++) s.push_back(rand_payload_byte());
				end
			end
			if (sent + s.size() >= RANDOM_BYTES * 2 / 3)
				calm = 1'b1;
			send_stream(s);
			sent += s.size();
		end
	endtask

	always @(negedge clk) begin
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_run = $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (nal_words_due.size() == 0) begin
				$error("unexpected word: payload_byte %0h sync_error %0b",
					payload_byte, sync_error);
				fails++;
			end else begin
				got_word = nal_words_due.pop_front();
				check_field("payload_byte", got_word.pbyte, payload_byte);
				check_field("first_of_unit", got_word.first, first_of_unit);
				check_field("last_of_unit", got_word.last, last_of_unit);
				check_field("start_code_size", got_word.code_sz, start_code_size);
				check_field("forbidden_zero", got_word.fz, forbidden_zero);
				check_field("reference_idc", got_word.idc, reference_idc);
				check_field("unit_type", got_word.utype, unit_type);
				check_field("unit_length", got_word.ulen, unit_length);
				check_field("sync_error", got_word.serr, sync_error);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("annexb_nal_unit_splitter: mismatch");
			$finish;
		end
	end

	initial begin
		clear_parser();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_units_and_codes();
		test_sync_loss();
		test_stream_end_hunting();
		test_random_streams();
		@(negedge clk);
		in_valid <= 1'b0;
		end_of_stream <= 1'b0;
		while (nal_words_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("annexb_nal_unit_splitter: match");
		else
			$display("annexb_nal_unit_splitter: mismatch");
		$finish;
	end
endmodule
